@@ design/slmc_pkg.sv @@
// shared types and constants for the sample logger mode controller
`timescale 1ns / 1ps

package slmc_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // action codes of a request beat
   localparam logic [2:0] ACTION_TICK = 3'd0;
   localparam logic [2:0] ACTION_BUTTON_ONE = 3'd1;
   localparam logic [2:0] ACTION_BUTTON_TWO = 3'd2;
   localparam logic [2:0] ACTION_SAMPLE = 3'd3;
   localparam logic [2:0] ACTION_PULL = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPTURE_BLINK_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_BLINK_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LED_ON_TICKS = 3'd4;

   // register reset values
   localparam logic [15:0] DEBOUNCE_TICKS_RESET = 16'd200;
   localparam logic [7:0] SAMPLE_INTERVAL_RESET = 8'd5;
   localparam logic [15:0] CAPTURE_BLINK_PERIOD_RESET = 16'd1000;
   localparam logic [15:0] HOLD_BLINK_PERIOD_RESET = 16'd500;
   localparam logic [15:0] LED_ON_TICKS_RESET = 16'd100;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_BUTTON_ONE,
      OP_BUTTON_TWO,
      OP_SAMPLE,
      OP_PULL,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] sample;
   } req_type;

   typedef struct packed {
      logic led;
      logic mode;
      logic start_conversion;
      logic dump_begin;
      logic dump_valid;
      logic [7:0] dump_value;
      logic dump_last;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic [7:0] sample;
   } cmd_type;

endpackage

@@ design/sample_logger_mode_controller.sv @@
// top level of the two-mode sample logger controller
//
// each request beat is one event: tick, an edge of either button, converter
// sample, dump pull or a spare code that does nothing; each event gives exactly
// one response beat carrying led, mode, conversion start and readout fields.
// the front end decodes request beats into a two-entry command queue; the
// back end executes one command per cycle unless a stalled response holds it,
// against the mode, debounce, blink phase and ring state, reads or writes the
// 1024-entry sample ring ram, and registers the response in an output stage.
// throughput: one beat per cycle while the response is not stalled; each event
// uses the ring at most once, for one read or one write.
// a request passes the command queue, the execute stage with its ring access
// and the output register before its response is valid.
// reset clears all mode and pointer state and loads the register defaults;
// the ring needs no clearing pass, since entries are judged written from the
// write slot and a wrap flag.
// while rsp_stall is high the response holds, the back end stops once its
// stages are full, and req_stall rises once the command queue is full.
// registers are to be written through csr_write_en only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module sample_logger_mode_controller #(
   parameter int RING_DEPTH = slmc_pkg::RING_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  slmc_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output slmc_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [slmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [slmc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic cmd_valid;
   logic cmd_pop;
   slmc_pkg::cmd_type cmd;

   slmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   slmc_back #(
      .RING_DEPTH(RING_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

endmodule

@@ design/slmc_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module slmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/slmc_front.sv @@
// request intake: action decode and command queue toward the back end
`timescale 1ns / 1ps

module slmc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slmc_pkg::req_type req_payload,
   output logic              cmd_valid,
   output slmc_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   localparam int QueueDepth = slmc_pkg::QUEUE_DEPTH;
   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   slmc_pkg::cmd_type entry_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   slmc_pkg::cmd_type decoded;
   logic push;

   always_comb begin
      decoded.sample = req_payload.sample;
      case (req_payload.action)
         slmc_pkg::ACTION_TICK: decoded.op = slmc_pkg::OP_TICK;
         slmc_pkg::ACTION_BUTTON_ONE: decoded.op = slmc_pkg::OP_BUTTON_ONE;
         slmc_pkg::ACTION_BUTTON_TWO: decoded.op = slmc_pkg::OP_BUTTON_TWO;
         slmc_pkg::ACTION_SAMPLE: decoded.op = slmc_pkg::OP_SAMPLE;
         slmc_pkg::ACTION_PULL: decoded.op = slmc_pkg::OP_PULL;
         default: decoded.op = slmc_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == CountWidth'(QueueDepth));
   assign push = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (cmd_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("command queue over depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("command popped from empty queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !cmd_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

@@ design/slmc_back.sv @@
// command execution: mode, debounce, phases, sample ring and response stage
`timescale 1ns / 1ps

module slmc_back #(
   parameter int RING_DEPTH = slmc_pkg::RING_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  slmc_pkg::cmd_type                    cmd,
   output logic                                 cmd_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output slmc_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [slmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [slmc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int SlotWidth = $clog2(RING_DEPTH);
   localparam logic [SlotWidth-1:0] LastSlot = SlotWidth'(RING_DEPTH - 1);

   function automatic logic [15:0] advance16(input logic [15:0] phase,
                                             input logic [15:0] period);
      logic [16:0] nxt;
      nxt = {1'b0, phase} + 17'd1;
      return (nxt >= {1'b0, period}) ? 16'd0 : nxt[15:0];
   endfunction

   function automatic logic [7:0] advance8(input logic [7:0] phase,
                                           input logic [7:0] period);
      logic [8:0] nxt;
      nxt = {1'b0, phase} + 9'd1;
      return (nxt >= {1'b0, period}) ? 8'd0 : nxt[7:0];
   endfunction

   // configuration
   logic [15:0] debounce_ticks_ff;
   logic [7:0] sample_interval_ff;
   logic [15:0] capture_blink_period_ff;
   logic [15:0] hold_blink_period_ff;
   logic [15:0] led_on_ticks_ff;

   // controller state
   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] last_accept_tick_ff, last_accept_tick_in;
   logic hold_mode_ff, hold_mode_in;
   logic [SlotWidth-1:0] write_slot_ff, write_slot_in;
   logic ring_wrapped_ff, ring_wrapped_in;
   logic [15:0] capture_phase_ff, capture_phase_in;
   logic [15:0] hold_phase_ff, hold_phase_in;
   logic [7:0] sample_phase_ff, sample_phase_in;
   logic dump_active_ff, dump_active_in;
   logic [SlotWidth-1:0] dump_slot_ff, dump_slot_in;

   // pipeline
   logic s1_valid_ff, s1_valid_in;
   slmc_pkg::rsp_type s1_rsp_ff, s1_rsp_in;
   logic s1_entry_ok_ff, s1_entry_ok_in;
   logic out_valid_ff, out_valid_in;
   slmc_pkg::rsp_type out_ff, out_in;

   logic exec_fire;
   logic s1_move;
   logic s1_free;
   logic button_ok;
   logic [15:0] gap;
   logic [15:0] led_phase;
   logic ram_we;
   logic ram_re;
   logic [7:0] ram_rd_data;

   assign s1_move = !out_valid_ff || !rsp_stall;
   assign s1_free = !s1_valid_ff || s1_move;
   assign exec_fire = cmd_valid && s1_free;
   assign cmd_pop = exec_fire;

   assign gap = tick_count_ff - last_accept_tick_ff;
   assign button_ok = (gap >= debounce_ticks_ff);

   always_comb begin
      tick_count_in = tick_count_ff;
      last_accept_tick_in = last_accept_tick_ff;
      hold_mode_in = hold_mode_ff;
      write_slot_in = write_slot_ff;
      ring_wrapped_in = ring_wrapped_ff;
      capture_phase_in = capture_phase_ff;
      hold_phase_in = hold_phase_ff;
      sample_phase_in = sample_phase_ff;
      dump_active_in = dump_active_ff;
      dump_slot_in = dump_slot_ff;
      s1_rsp_in = '0;
      s1_entry_ok_in = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      if (exec_fire) begin
         case (cmd.op)
            slmc_pkg::OP_TICK: begin
               tick_count_in = tick_count_ff + 16'd1;
               capture_phase_in = advance16(capture_phase_ff, capture_blink_period_ff);
               hold_phase_in = advance16(hold_phase_ff, hold_blink_period_ff);
               sample_phase_in = advance8(sample_phase_ff, sample_interval_ff);
               s1_rsp_in.start_conversion = (sample_phase_in == 8'd0) && !hold_mode_ff;
            end
            slmc_pkg::OP_BUTTON_ONE: begin
               if (button_ok) begin
                  last_accept_tick_in = tick_count_ff;
                  dump_active_in = 1'b0;
                  hold_mode_in = !hold_mode_ff;
                  if (hold_mode_ff) begin
                     // back to capture: ring reads as empty again
                     write_slot_in = '0;
                     ring_wrapped_in = 1'b0;
                  end
               end
            end
            slmc_pkg::OP_BUTTON_TWO: begin
               if (button_ok) begin
                  last_accept_tick_in = tick_count_ff;
                  dump_active_in = hold_mode_ff;
                  if (hold_mode_ff) begin
                     dump_slot_in = '0;
                     s1_rsp_in.dump_begin = 1'b1;
                  end
               end
            end
            slmc_pkg::OP_SAMPLE: begin
               ram_we = 1'b1;
               if (write_slot_ff == LastSlot) begin
                  write_slot_in = '0;
                  ring_wrapped_in = 1'b1;
               end else begin
                  write_slot_in = write_slot_ff + 1'b1;
               end
            end
            slmc_pkg::OP_PULL: begin
               if (dump_active_ff) begin
                  ram_re = 1'b1;
                  s1_rsp_in.dump_valid = 1'b1;
                  s1_entry_ok_in = ring_wrapped_ff || (dump_slot_ff < write_slot_ff);
                  if (dump_slot_ff == LastSlot) begin
                     s1_rsp_in.dump_last = 1'b1;
                     dump_active_in = 1'b0;
                  end
                  dump_slot_in = dump_slot_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      led_phase = hold_mode_in ? hold_phase_in : capture_phase_in;
      s1_rsp_in.led = (led_phase <= led_on_ticks_ff);
      s1_rsp_in.mode = hold_mode_in;
   end

   assign s1_valid_in = s1_free ? exec_fire : s1_valid_ff;
   assign out_valid_in = s1_move ? s1_valid_ff : out_valid_ff;

   always_comb begin
      out_in = s1_rsp_ff;
      out_in.dump_value = s1_entry_ok_ff ? ram_rd_data : 8'd0;
   end

   slmc_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(write_slot_ff),
      .wr_data(cmd.sample),
      .rd_en  (ram_re),
      .rd_addr(dump_slot_ff),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= slmc_pkg::DEBOUNCE_TICKS_RESET;
         sample_interval_ff <= slmc_pkg::SAMPLE_INTERVAL_RESET;
         capture_blink_period_ff <= slmc_pkg::CAPTURE_BLINK_PERIOD_RESET;
         hold_blink_period_ff <= slmc_pkg::HOLD_BLINK_PERIOD_RESET;
         led_on_ticks_ff <= slmc_pkg::LED_ON_TICKS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            slmc_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_write_data[15:0];
            slmc_pkg::CSR_SAMPLE_INTERVAL: sample_interval_ff <= csr_write_data[7:0];
            slmc_pkg::CSR_CAPTURE_BLINK_PERIOD: capture_blink_period_ff <= csr_write_data[15:0];
            slmc_pkg::CSR_HOLD_BLINK_PERIOD: hold_blink_period_ff <= csr_write_data[15:0];
            slmc_pkg::CSR_LED_ON_TICKS: led_on_ticks_ff <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         last_accept_tick_ff <= '0;
         hold_mode_ff <= 1'b0;
         write_slot_ff <= '0;
         ring_wrapped_ff <= 1'b0;
         capture_phase_ff <= '0;
         hold_phase_ff <= '0;
         sample_phase_ff <= '0;
         dump_active_ff <= 1'b0;
         dump_slot_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         last_accept_tick_ff <= last_accept_tick_in;
         hold_mode_ff <= hold_mode_in;
         write_slot_ff <= write_slot_in;
         ring_wrapped_ff <= ring_wrapped_in;
         capture_phase_ff <= capture_phase_in;
         hold_phase_ff <= hold_phase_in;
         sample_phase_ff <= sample_phase_in;
         dump_active_ff <= dump_active_in;
         dump_slot_ff <= dump_slot_in;
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_rsp_ff <= s1_rsp_in;
         s1_entry_ok_ff <= s1_entry_ok_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   a_one_ring_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring read and write in the same cycle");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> s1_valid_ff && $stable(ram_rd_data))
      else $error("ring read data lost while the response stage waits");

   a_empty_dump_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.dump_valid) |-> (out_ff.dump_value == 8'd0 && !out_ff.dump_last))
      else $error("dump fields set without a ring entry");

   a_begin_resets_slot: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && s1_rsp_in.dump_begin) |=> (dump_active_ff && dump_slot_ff == '0))
      else $error("readout start did not rewind the dump slot");

endmodule

@@ tb/sv/sample_logger_mode_controller_tb.sv @@
// self-checking testbench for the two-mode sample logger mode controller
`timescale 1ns / 1ps

module sample_logger_mode_controller_tb;

   localparam int SLOT_WIDTH = $clog2(slmc_pkg::RING_DEPTH);
   localparam logic [SLOT_WIDTH:0] SLOT_COUNT = (SLOT_WIDTH + 1)'(slmc_pkg::RING_DEPTH);
   localparam int PLAN_MODEL = 0;
   localparam int CHECK_MODEL = 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLDOFF_AFTER = 600;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int FIXED_PHASES = 4;
   localparam int PHASES = 8;
   localparam logic [2:0] ACTION_FIRST_SPARE = slmc_pkg::ACTION_PULL + 3'd1;
   localparam logic [2:0] ACTION_LAST_SPARE = 3'd7;

   typedef struct packed {
      logic [15:0] debounce;
      logic [7:0]  interval;
      logic [15:0] capture_period;
      logic [15:0] hold_period;
      logic [15:0] led_on;
   } logger_cfg_type;

   typedef struct packed {
      logic [15:0]         tick_count;
      logic [15:0]         last_accept;
      logic                hold_mode;
      logic [SLOT_WIDTH-1:0] write_slot;
      logic [15:0]         capture_phase;
      logic [15:0]         hold_phase;
      logic [7:0]          sample_phase;
      logic                dump_active;
      logic [SLOT_WIDTH:0] dump_slot;
   } logger_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   slmc_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   slmc_pkg::rsp_type rsp_payload;
   logic csr_write_en = 1'b0;
   logic [slmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [slmc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   logger_cfg_type cfg;
   logger_state_type st [2];
   bit [7:0] ring_byte [2][slmc_pkg::RING_DEPTH];
   bit ring_live [2][slmc_pkg::RING_DEPTH];
   bit ever_written [slmc_pkg::RING_DEPTH];

   slmc_pkg::req_type event_queue [$];
   slmc_pkg::rsp_type status_due [$];
   slmc_pkg::rsp_type got_beat;
   slmc_pkg::rsp_type want_beat;

   int gap_left = 0;
   int send_calm = 0;
   int stall_left = 0;
   int stall_calm = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;
   int results_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int generated = 0;
   int settings_used = 0;
   int mode_flips = 0;
   int readouts_begun = 0;
   int readouts_done = 0;
   int conversions = 0;
   logic last_mode = 1'b0;

   sample_logger_mode_controller dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] phase_step(logic [15:0] phase, logic [15:0] period);
      logic [16:0] bumped;
      bumped = {1'b0, phase} + 17'd1;
      return (bumped >= {1'b0, period}) ? 16'd0 : bumped[15:0];
   endfunction

   function automatic slmc_pkg::rsp_type predict_status(int m, slmc_pkg::req_type r);
      slmc_pkg::rsp_type res;
      logic [15:0] since;
      logic [15:0] phase;
      logic [SLOT_WIDTH-1:0] slot;
      int i;
      res = '0;
      case (r.action)
         slmc_pkg::ACTION_TICK: begin
            st[m].tick_count = st[m].tick_count + 16'd1;
            st[m].capture_phase = phase_step(st[m].capture_phase, cfg.capture_period);
            st[m].hold_phase = phase_step(st[m].hold_phase, cfg.hold_period);
            st[m].sample_phase = 8'(phase_step({8'd0, st[m].sample_phase}, {8'd0, cfg.interval}));
            res.start_conversion = (st[m].sample_phase == 8'd0) && !st[m].hold_mode;
         end
         slmc_pkg::ACTION_BUTTON_ONE, slmc_pkg::ACTION_BUTTON_TWO: begin
            since = st[m].tick_count - st[m].last_accept;
            if (since >= cfg.debounce) begin
               st[m].last_accept = st[m].tick_count;
               st[m].dump_active = 1'b0;
               if (r.action == slmc_pkg::ACTION_BUTTON_ONE) begin
                  st[m].hold_mode = !st[m].hold_mode;
                  if (!st[m].hold_mode) begin
                     for (i = 0; i < slmc_pkg::RING_DEPTH; i++) ring_live[m][i] = 1'b0;
                     st[m].write_slot = '0;
                  end
               end else if (st[m].hold_mode) begin
                  st[m].dump_active = 1'b1;
                  st[m].dump_slot = '0;
                  res.dump_begin = 1'b1;
               end
            end
         end
         slmc_pkg::ACTION_SAMPLE: begin
            ring_byte[m][st[m].write_slot] = r.sample;
            ring_live[m][st[m].write_slot] = 1'b1;
            if (st[m].write_slot == SLOT_WIDTH'(slmc_pkg::RING_DEPTH - 1)) st[m].write_slot = '0;
            else st[m].write_slot = st[m].write_slot + 1'b1;
         end
         slmc_pkg::ACTION_PULL: begin
            if (st[m].dump_active && st[m].dump_slot < SLOT_COUNT) begin
               slot = st[m].dump_slot[SLOT_WIDTH-1:0];
               res.dump_valid = 1'b1;
               res.dump_value = ring_live[m][slot] ? ring_byte[m][slot] : 8'd0;
               if (st[m].dump_slot == SLOT_COUNT - 1'b1) begin
                  res.dump_last = 1'b1;
                  st[m].dump_active = 1'b0;
               end
               st[m].dump_slot = st[m].dump_slot + 1'b1;
            end else begin
               st[m].dump_active = 1'b0;
            end
         end
         default: begin
         end
      endcase
      phase = st[m].hold_mode ? st[m].hold_phase : st[m].capture_phase;
      res.led = (phase <= cfg.led_on);
      res.mode = st[m].hold_mode;
      return res;
   endfunction

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int idle_length(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(40, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats pending and %0d due", $time,
                  event_queue.size(), status_due.size());
         $display("FAIL sample_logger_mode_controller");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) status_due.push_back(predict_status(CHECK_MODEL, req_payload));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (event_queue.size() != 0) begin
               req_payload <= event_queue.pop_front();
               req_valid <= 1'b1;
               gap_left = idle_length(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_beat = rsp_payload;
            results_seen++;
            if (status_due.size() == 0) begin
               $display("%0t: response beat with nothing expected, got %p", $time, got_beat);
               mismatches++;
            end else begin
               want_beat = status_due.pop_front();
               check_field("led", 8'(want_beat.led), 8'(got_beat.led));
               check_field("mode", 8'(want_beat.mode), 8'(got_beat.mode));
               check_field("start_conversion", 8'(want_beat.start_conversion),
                           8'(got_beat.start_conversion));
               check_field("dump_begin", 8'(want_beat.dump_begin), 8'(got_beat.dump_begin));
               check_field("dump_valid", 8'(want_beat.dump_valid), 8'(got_beat.dump_valid));
               check_field("dump_value", want_beat.dump_value, got_beat.dump_value);
               check_field("dump_last", 8'(want_beat.dump_last), 8'(got_beat.dump_last));
            end
            if (got_beat.mode !== last_mode) mode_flips++;
            last_mode = got_beat.mode;
            if (got_beat.start_conversion === 1'b1) conversions++;
            if (got_beat.dump_begin === 1'b1) readouts_begun++;
            if (got_beat.dump_last === 1'b1) readouts_done++;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_length(stall_calm);
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // queue one event, stepping the planning copy so later choices see its state
   task automatic send(logic [2:0] action, logic [7:0] sample);
      slmc_pkg::req_type r;
      r.action = action;
      r.sample = sample;
      // never pull a ring entry that has not been written since reset
      if (action == slmc_pkg::ACTION_PULL && st[PLAN_MODEL].dump_active
          && st[PLAN_MODEL].dump_slot < SLOT_COUNT
          && !ever_written[st[PLAN_MODEL].dump_slot[SLOT_WIDTH-1:0]])
         r.action = slmc_pkg::ACTION_TICK;
      if (r.action == slmc_pkg::ACTION_SAMPLE) ever_written[st[PLAN_MODEL].write_slot] = 1'b1;
      void'(predict_status(PLAN_MODEL, r));
      event_queue.push_back(r);
      generated++;
   endtask

   task automatic press(logic [2:0] button);
      logic [15:0] since;
      since = st[PLAN_MODEL].tick_count - st[PLAN_MODEL].last_accept;
      while (cfg.debounce <= 16'd64 && since < cfg.debounce) begin
         send(slmc_pkg::ACTION_TICK, 8'($urandom));
         since = st[PLAN_MODEL].tick_count - st[PLAN_MODEL].last_accept;
      end
      send(button, 8'($urandom));
   endtask

   task automatic enter_mode(logic hold);
      if (st[PLAN_MODEL].hold_mode != hold) press(slmc_pkg::ACTION_BUTTON_ONE);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (event_queue.size() != 0 || req_valid || status_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [slmc_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic apply_config(logger_cfg_type c);
      drain();
      csr_write(slmc_pkg::CSR_DEBOUNCE_TICKS, c.debounce);
      csr_write(slmc_pkg::CSR_SAMPLE_INTERVAL, {8'd0, c.interval});
      csr_write(slmc_pkg::CSR_CAPTURE_BLINK_PERIOD, c.capture_period);
      csr_write(slmc_pkg::CSR_HOLD_BLINK_PERIOD, c.hold_period);
      csr_write(slmc_pkg::CSR_LED_ON_TICKS, c.led_on);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      cfg = c;
      settings_used++;
   endtask

   // fill the whole ring with a wrap, then read every entry back to the end
   task automatic full_readout();
      int i;
      enter_mode(1'b0);
      for (i = 0; i < slmc_pkg::RING_DEPTH + 8; i++) begin
         send(slmc_pkg::ACTION_SAMPLE, 8'($urandom));
         if (i % 256 == 0) send(slmc_pkg::ACTION_TICK, 8'($urandom));
      end
      enter_mode(1'b1);
      press(slmc_pkg::ACTION_BUTTON_TWO);
      while (st[PLAN_MODEL].dump_active) begin
         if ($urandom_range(0, 127) == 0) send(slmc_pkg::ACTION_TICK, 8'($urandom));
         else send(slmc_pkg::ACTION_PULL, 8'($urandom));
      end
      send(slmc_pkg::ACTION_PULL, 8'($urandom));
   endtask

   task automatic random_mix(int budget);
      int first;
      int n;
      int r;
      first = generated;
      while (generated - first < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               enter_mode(1'b0);
               n = $urandom_range(1, 16);
               repeat (n) begin
                  if ($urandom_range(0, 2) == 0) send(slmc_pkg::ACTION_TICK, 8'($urandom));
                  else send(slmc_pkg::ACTION_SAMPLE, 8'($urandom));
               end
            end
            3, 4, 5: begin
               enter_mode(1'b1);
               if ($urandom_range(0, 3) == 0) send(slmc_pkg::ACTION_SAMPLE, 8'($urandom));
               press(slmc_pkg::ACTION_BUTTON_TWO);
               n = $urandom_range(1, 24);
               repeat (n) begin
                  r = $urandom_range(0, 19);
                  if (r < 15) send(slmc_pkg::ACTION_PULL, 8'($urandom));
                  else if (r < 18) send(slmc_pkg::ACTION_TICK, 8'($urandom));
                  else if (r == 18) send(slmc_pkg::ACTION_BUTTON_TWO, 8'($urandom));
                  else send(3'($urandom_range(ACTION_FIRST_SPARE, ACTION_LAST_SPARE)),
                            8'($urandom));
               end
            end
            6, 7: begin
               n = $urandom_range(1, 8);
               repeat (n) send(3'($urandom_range(0, 7)), 8'($urandom));
            end
            default: begin
               n = $urandom_range(5, 30);
               repeat (n) send(slmc_pkg::ACTION_TICK, 8'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      logger_cfg_type plan [FIXED_PHASES];
      logger_cfg_type c;
      int a;
      int p;
      cfg = '{slmc_pkg::DEBOUNCE_TICKS_RESET, slmc_pkg::SAMPLE_INTERVAL_RESET,
              slmc_pkg::CAPTURE_BLINK_PERIOD_RESET, slmc_pkg::HOLD_BLINK_PERIOD_RESET,
              slmc_pkg::LED_ON_TICKS_RESET};
      st[PLAN_MODEL] = '0;
      st[CHECK_MODEL] = '0;
      plan[0] = '{16'd3, 8'd3, 16'd7, 16'd5, 16'd2};
      plan[1] = '{16'd0, 8'd1, 16'd1, 16'd1, 16'd0};
      plan[2] = '{16'hffff, 8'hff, 16'hffff, 16'hffff, 16'hffff};
      plan[3] = '{16'd1, 8'd2, 16'hffff, 16'd3, 16'hfffe};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: presses inside the window after reset are ignored
      send(slmc_pkg::ACTION_TICK, 8'h00);
      send(slmc_pkg::ACTION_SAMPLE, 8'h00);
      send(slmc_pkg::ACTION_SAMPLE, 8'hff);
      send(slmc_pkg::ACTION_PULL, 8'h00);
      send(slmc_pkg::ACTION_BUTTON_ONE, 8'hff);
      send(slmc_pkg::ACTION_BUTTON_TWO, 8'h00);
      for (a = int'(ACTION_FIRST_SPARE); a <= int'(ACTION_LAST_SPARE); a++)
         send(3'(a), 8'($urandom));

      // zero periods and no debounce window
      apply_config('{16'd0, 8'd0, 16'd0, 16'd0, 16'd0});
      send(slmc_pkg::ACTION_TICK, 8'h00);
      send(slmc_pkg::ACTION_TICK, 8'hff);
      send(slmc_pkg::ACTION_BUTTON_ONE, 8'h00);
      send(slmc_pkg::ACTION_SAMPLE, 8'h5a);
      send(slmc_pkg::ACTION_BUTTON_TWO, 8'h00);
      send(slmc_pkg::ACTION_PULL, 8'h00);
      send(slmc_pkg::ACTION_PULL, 8'h00);
      send(slmc_pkg::ACTION_PULL, 8'h00);
      send(slmc_pkg::ACTION_BUTTON_ONE, 8'h00);
      send(slmc_pkg::ACTION_BUTTON_TWO, 8'h00);
      send(slmc_pkg::ACTION_PULL, 8'h00);
      send(slmc_pkg::ACTION_TICK, 8'h00);
      send(slmc_pkg::ACTION_SAMPLE, 8'h81);

      for (p = 0; p < PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            c = plan[p];
         end else begin
            c.debounce = 16'($urandom_range(0, 6));
            c.interval = ($urandom_range(0, 4) == 0) ? 8'hff : 8'($urandom_range(1, 12));
            c.capture_period = 16'($urandom_range(1, 40));
            c.hold_period = 16'($urandom_range(1, 40));
            c.led_on = 16'($urandom_range(0, 45));
         end
         apply_config(c);
         if (p == 0) full_readout();
         random_mix(p == 2 ? 6 : 8);
      end
      drain();

      $display("run covered %0d event beats under %0d register settings", results_seen,
               settings_used);
      $display("%0d mode changes, %0d readouts started, %0d run to the end, %0d conversion starts",
               mode_flips, readouts_begun, readouts_done, conversions);
      if (mismatches == 0) begin
         $display("PASS sample_logger_mode_controller");
      end else begin
         $display("FAIL sample_logger_mode_controller");
      end
      $finish;
   end

endmodule
